FILE: design/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg
// shared constants and types of the ordered list store
// ----------------------------------------------------------------------------
package olst_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int LENGTH_W = 7;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic               cmp;
		logic [VALUE_W-1:0] value;
	} cell_ctrl_t;

endpackage

FILE: design/ordered_list_store.sv
// the result strobe comes in the cycle after the item is taken
// throughput: 1 item per cycle, busy stays low; every cell shifts or compares
//   in the same cycle, and the match bits are gathered in the result cycle
// reset: the element count is cleared at once, no clearing pass over the cells
// the receiver cannot stall; each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
// ordered_list_store
// bounded ordered list held in a row of shifting cells
// ----------------------------------------------------------------------------
module ordered_list_store #(
	parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic signed [olst_pkg::VALUE_W-1:0] item_value,
	input  logic [olst_pkg::POS_W-1:0]          position,
	output logic                                done,
	output logic [1:0]                          status,
	output logic                                found,
	output logic signed [olst_pkg::VALUE_W-1:0] head_value,
	output logic [olst_pkg::LENGTH_W-1:0]       length
);
	import olst_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic             accept;
	logic [CNT_W-1:0] count_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic             full;
	logic             empty;
	logic             ins_ok;
	logic             rem_ok;
	logic [CMP_W-1:0] pos_m1;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] idx_full;
	logic [IDX_W-1:0] ins_idx;
	cell_ctrl_t       ctrl;

	logic [VALUE_W-1:0]  cell_data [CAPACITY];
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] in_list;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign ins_ok = accept && (mode == MODE_INSERT) && !full;
	assign rem_ok = accept && (mode == MODE_REMOVE) && !empty;

	// insert slot: position minus one, head for 0 or 1, clamped to the tail
	assign pos_m1   = (position <= POS_W'(1)) ? '0 : CMP_W'(position - POS_W'(1));
	assign cnt_ext  = CMP_W'(count_q);
	assign idx_full = (pos_m1 > cnt_ext) ? cnt_ext : pos_m1;
	assign ins_idx  = idx_full[IDX_W-1:0];

	assign ctrl.ins   = ins_ok;
	assign ctrl.rem   = rem_ok;
	assign ctrl.cmp   = accept && (mode == MODE_LOOKUP);
	assign ctrl.value = item_value;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [VALUE_W-1:0] left_d;
			logic [VALUE_W-1:0] right_d;

			assign in_list[gi] = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign left_d = item_value;
			end else begin : g_mid
				assign left_d = cell_data[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_tail
				assign right_d = cell_data[gi];
			end else begin : g_body
				assign right_d = cell_data[gi+1];
			end

			olst_cell #(
				.INDEX (gi),
				.IDX_W (IDX_W)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.ins_idx    (ins_idx),
				.in_list    (in_list[gi]),
				.left_data  (left_d),
				.right_data (right_d),
				.data       (cell_data[gi]),
				.match      (match_vec[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ins_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rem_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if ((mode == MODE_INSERT) && full) begin
				status_q <= STATUS_FULL;
			end else if ((mode == MODE_REMOVE) && empty) begin
				status_q <= STATUS_EMPTY;
			end else begin
				status_q <= STATUS_OK;
			end
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign found      = |match_vec;
	assign head_value = empty ? '0 : signed'(cell_data[0]);
	assign length     = LENGTH_W'(count_q);

endmodule

FILE: design/olst_cell.sv
// ----------------------------------------------------------------------------
// olst_cell
// one list slot: shifts toward the tail on insert, toward the head on remove,
// compares its word against the lookup value
// ----------------------------------------------------------------------------
module olst_cell #(
	parameter int INDEX = 0,
	parameter int IDX_W = 6
) (
	input  logic                         clk,
	input  olst_pkg::cell_ctrl_t         ctrl,
	input  logic [IDX_W-1:0]             ins_idx,
	input  logic                         in_list,
	input  logic [olst_pkg::VALUE_W-1:0] left_data,
	input  logic [olst_pkg::VALUE_W-1:0] right_data,
	output logic [olst_pkg::VALUE_W-1:0] data,
	output logic                         match
);
	import olst_pkg::*;

	localparam logic [IDX_W-1:0] SLOT = IDX_W'(INDEX);

	logic [VALUE_W-1:0] data_q;
	logic               match_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (SLOT == ins_idx) begin
				data_q <= ctrl.value;
			end else if (SLOT > ins_idx) begin
				data_q <= left_data;
			end
		end else if (ctrl.rem) begin
			data_q <= right_data;
		end
		match_q <= ctrl.cmp && in_list && (data_q == ctrl.value);
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

FILE: design/olst_checker.sv
// ----------------------------------------------------------------------------
// olst_checker
// port-level checks of the ordered list store, bound to the top level
// ----------------------------------------------------------------------------
module olst_checker #(
	parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [1:0]                          mode,
	input logic                                done,
	input logic [1:0]                          status,
	input logic                                found,
	input logic [olst_pkg::LENGTH_W-1:0]       length
);
	import olst_pkg::*;

	// one result for every item, in the cycle after it is taken
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (done == $past(start && !busy)))
		else $error("result strobe does not follow item");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STATUS_EMPTY)) |-> (length == '0))
		else $error("remove error with nonzero length");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STATUS_FULL)) |-> (length == LENGTH_W'(CAPACITY)))
		else $error("full error below capacity");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> ((status == STATUS_OK) && ($past(mode) == MODE_LOOKUP)))
		else $error("found flag outside a lookup");

endmodule

bind ordered_list_store olst_checker #(.CAPACITY(CAPACITY)) u_olst_checker (.*);

FILE: tb/tb_ordered_list_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_list_store
// drives insert, remove, lookup and no-op items into the list store and checks
// every result strobe against a queue-based shadow of the list
// ----------------------------------------------------------------------------
module tb_ordered_list_store;

	import olst_pkg::*;

	localparam int          CAP        = CAPACITY_DEF;
	localparam logic [1:0]  MODE_NOP   = 2'd3;
	localparam int          IDLE_LIMIT = 400;
	localparam int          RAND_ITEMS = 1230;

	typedef struct {
		logic [1:0]                status;
		logic                      found;
		logic signed [VALUE_W-1:0] head;
		logic [LENGTH_W-1:0]       length;
	} list_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [1:0]                  mode;
	logic signed [VALUE_W-1:0]   item_value;
	logic [POS_W-1:0]            position;
	logic                        done;
	logic [1:0]                  status;
	logic                        found;
	logic signed [VALUE_W-1:0]   head_value;
	logic [LENGTH_W-1:0]         length;

	logic signed [VALUE_W-1:0]   shadow_list[$];
	list_result_t                pending_results[$];

	int error_count;
	int item_count;
	int result_count;
	int full_rejects;
	int empty_removes;
	int lookup_hits;
	int nop_count;
	int peak_length;
	int burst_left;
	int idle_cycles;

	ordered_list_store #(
		.CAPACITY(CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.item_value(item_value),
		.position(position),
		.done(done),
		.status(status),
		.found(found),
		.head_value(head_value),
		.length(length)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// update the shadow list and queue the result this item should produce
	task automatic predict_list_op(input logic [1:0] m, input logic signed [VALUE_W-1:0] v,
			input logic [POS_W-1:0] p);
		list_result_t r;
		int           idx;
		r.status = STATUS_OK;
		r.found  = 1'b0;
		case (m)
			MODE_INSERT: begin
				if (shadow_list.size() >= CAP) begin
					r.status = STATUS_FULL;
					full_rejects++;
				end else begin
					idx = (p <= 1) ? 0 : int'(p) - 1;
					if (idx > shadow_list.size())
						idx = shadow_list.size();
					shadow_list.insert(idx, v);
				end
			end
			MODE_REMOVE: begin
				if (shadow_list.size() == 0) begin
					r.status = STATUS_EMPTY;
					empty_removes++;
				end else begin
					void'(shadow_list.pop_front());
				end
			end
			MODE_LOOKUP: begin
				foreach (shadow_list[i])
					if (shadow_list[i] == v)
						r.found = 1'b1;
				if (r.found)
					lookup_hits++;
			end
			default: nop_count++;
		endcase
		r.head   = (shadow_list.size() > 0) ? shadow_list[0] : '0;
		r.length = LENGTH_W'(shadow_list.size());
		if (shadow_list.size() > peak_length)
			peak_length = shadow_list.size();
		pending_results.push_back(r);
	endtask

	// present one item after a random gap and hold it until it is taken
	task automatic send_item(input logic [1:0] m, input logic signed [VALUE_W-1:0] v,
			input logic [POS_W-1:0] p);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else if ($urandom_range(0, 7) == 0) begin
			gap = 0;
			burst_left = $urandom_range(5, 30);
		end else begin
			gap = $urandom_range(0, 12);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		mode       <= m;
		item_value <= v;
		position   <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_list_op(m, v, p);
		item_count++;
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2, 3: return $signed($urandom_range(0, 16)) - 8;
			default: return $signed($urandom);
		endcase
	endfunction

	task automatic test_empty_list();
		send_item(MODE_REMOVE, 32'sd0, 8'd0);
		send_item(MODE_LOOKUP, 32'sd0, 8'd0);
		send_item(MODE_NOP, 32'sd0, 8'd0);
	endtask

	task automatic test_insert_positions();
		send_item(MODE_INSERT, 32'sh7FFFFFFF, 8'd0);
		send_item(MODE_INSERT, 32'sh80000000, 8'd1);
		send_item(MODE_INSERT, -32'sd1, 8'd255);
		send_item(MODE_INSERT, 32'sd0, 8'd2);
		send_item(MODE_INSERT, 32'sd5, 8'd5);
		send_item(MODE_INSERT, 32'sd7, 8'd3);
	endtask

	task automatic test_lookup();
		send_item(MODE_LOOKUP, 32'sh80000000, 8'hFF);
		send_item(MODE_LOOKUP, 32'sh7FFFFFFF, 8'h00);
		send_item(MODE_LOOKUP, -32'sd1, 8'hAA);
		send_item(MODE_LOOKUP, 32'sd12345, 8'h55);
		send_item(MODE_LOOKUP, 32'sh7FFFFFFE, 8'd1);
	endtask

	task automatic test_undefined_mode();
		send_item(MODE_NOP, 32'sh5A5AA5A5, 8'd3);
	endtask

	task automatic test_remove_to_empty();
		repeat (7)
			send_item(MODE_REMOVE, $signed($urandom), 8'($urandom));
	endtask

	// phases lean toward filling, draining or a balanced mix
	task automatic test_random_mix(input int n_items);
		int                        bias;
		int                        roll;
		logic [1:0]                m;
		logic signed [VALUE_W-1:0] v;
		logic [POS_W-1:0]          p;
		bias = 0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 125 == 0)
				bias = (i / 125) % 3;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				m = MODE_NOP;
			else if (bias == 0)
				m = (roll < 78) ? MODE_INSERT : (roll < 88) ? MODE_REMOVE : MODE_LOOKUP;
			else if (bias == 1)
				m = (roll < 13) ? MODE_INSERT : (roll < 85) ? MODE_REMOVE : MODE_LOOKUP;
			else
				m = (roll < 38) ? MODE_INSERT : (roll < 66) ? MODE_REMOVE : MODE_LOOKUP;
			if (m == MODE_LOOKUP && shadow_list.size() > 0 && $urandom_range(0, 1))
				v = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
			else
				v = pick_value();
			if ($urandom_range(0, 9) < 6)
				p = POS_W'($urandom_range(0, shadow_list.size() + 2));
			else
				p = POS_W'($urandom);
			send_item(m, v, p);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with no item pending: status %0d len %0d",
					status, length));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d", status, want.status));
				if (found !== want.found)
					report_mismatch($sformatf("found got %b want %b", found, want.found));
				if (head_value !== want.head)
					report_mismatch($sformatf("head_value got %0d want %0d",
						head_value, want.head));
				if (length !== want.length)
					report_mismatch($sformatf("length got %0d want %0d", length, want.length));
			end
		end
	end

	// watchdog
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		error_count   = 0;
		item_count    = 0;
		result_count  = 0;
		full_rejects  = 0;
		empty_removes = 0;
		lookup_hits   = 0;
		nop_count     = 0;
		peak_length   = 0;
		burst_left    = 0;
		arst_n        = 1'b0;
		start         = 1'b0;
		mode          = MODE_INSERT;
		item_value    = '0;
		position      = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_insert_positions();
		test_lookup();
		test_undefined_mode();
		test_remove_to_empty();
		test_random_mix(RAND_ITEMS);

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("ran %0d items, checked %0d results, peak length %0d of %0d",
			item_count, result_count, peak_length, CAP);
		$display("full rejects %0d, empty removes %0d, lookup hits %0d, no-ops %0d",
			full_rejects, empty_removes, lookup_hits, nop_count);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
